/* rtl/fletcher32_image_checksum_macros.svh */
// assertion macros shared by the checksum checker
// depends on nothing; included by files that hold concurrent assertions
`ifndef FLETCHER32_IMAGE_CHECKSUM_MACROS_SVH
`define FLETCHER32_IMAGE_CHECKSUM_MACROS_SVH

// same-cycle implication, disabled during reset
`define F32IC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("checksum assertion failed");

// next-cycle implication, disabled during reset
`define F32IC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("checksum assertion failed");

`endif

/* rtl/f32ic_pkg.sv */
// types, constants and the fold adder of the fletcher-32 checksum block
// depends on nothing; imported by every checksum module
package f32ic_pkg;

   localparam int SUM_WIDTH = 16;
   localparam int BYTE_WIDTH = 8;
   localparam int CHECK_WIDTH = 2 * SUM_WIDTH;
   localparam logic [SUM_WIDTH-1:0] SUM_RESET = 16'hffff;

   // one input item as held in the input register
   typedef struct packed {
      logic [SUM_WIDTH-1:0] data_word;
      logic                 lone_byte;
      logic                 last_item;
   } item_type;

   // add with end-around carry; inputs in 0..65535, no second carry possible
   function automatic logic [SUM_WIDTH-1:0] fold_add(
      input logic [SUM_WIDTH-1:0] a,
      input logic [SUM_WIDTH-1:0] b
   );
      logic [SUM_WIDTH:0] raw;
      raw = {1'b0, a} + {1'b0, b};
      return raw[SUM_WIDTH-1:0] + {{(SUM_WIDTH-1){1'b0}}, raw[SUM_WIDTH]};
   endfunction

endpackage

/* rtl/f32ic_in_reg.sv */
// input register of the checksum block: holds one item until the sums take it
// depends on f32ic_pkg
module f32ic_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  f32ic_pkg::item_type req_item,
   input  logic                advance,
   output logic                req_stall,
   output logic                item_valid,
   output f32ic_pkg::item_type item
);
   import f32ic_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   // a held item that cannot move on blocks the next transfer
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   // next-state logic
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/f32ic_sum_unit.sv */
// running fletcher-32 sums with end-around-carry folding
// depends on f32ic_pkg
module f32ic_sum_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  f32ic_pkg::item_type                  item,
   input  logic                                 advance,
   output logic [f32ic_pkg::CHECK_WIDTH-1:0]    check_value
);
   import f32ic_pkg::*;

   logic [SUM_WIDTH-1:0] first_sum_ff, first_sum_in;
   logic [SUM_WIDTH-1:0] second_sum_ff, second_sum_in;
   logic [SUM_WIDTH-1:0] word;
   logic [SUM_WIDTH-1:0] first_new;
   logic [SUM_WIDTH-1:0] second_new;

   // lone trailing byte keeps only its low byte
   assign word = item.lone_byte
      ? {{(SUM_WIDTH-BYTE_WIDTH){1'b0}}, item.data_word[BYTE_WIDTH-1:0]}
      : item.data_word;

   // two chained fold adds
   assign first_new   = fold_add(first_sum_ff, word);
   assign second_new  = fold_add(second_sum_ff, first_new);
   assign check_value = {second_new, first_new};

   // sums restart after the last item of an image
   always_comb begin
      first_sum_in  = first_sum_ff;
      second_sum_in = second_sum_ff;
      if (advance) begin
         if (item.last_item) begin
            first_sum_in  = SUM_RESET;
            second_sum_in = SUM_RESET;
         end else begin
            first_sum_in  = first_new;
            second_sum_in = second_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sum_ff  <= SUM_RESET;
         second_sum_ff <= SUM_RESET;
      end else begin
         first_sum_ff  <= first_sum_in;
         second_sum_ff <= second_sum_in;
      end
   end

endmodule

/* rtl/f32ic_out_reg.sv */
// result register of the checksum block: holds one check value until taken
// depends on f32ic_pkg
module f32ic_out_reg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [f32ic_pkg::CHECK_WIDTH-1:0] load_value,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic                              slot_free,
   output logic [f32ic_pkg::CHECK_WIDTH-1:0] rsp_check_value
);
   import f32ic_pkg::*;

   logic                   valid_ff, valid_in;
   logic [CHECK_WIDTH-1:0] value_ff, value_in;

   // slot can take a new result when empty or emptying this cycle
   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (load) begin
         valid_in = 1'b1;
         value_in = load_value;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_check_value = value_ff;

endmodule

/* rtl/fletcher32_image_checksum.sv */
// Fletcher-32 checksum over a pixel stream of little-endian 16-bit words, with an
// optional lone trailing byte. One item is taken every clock cycle unless the input
// stalls. An item is held in the input register; from there it is folded into both
// running sums through two chained end-around-carry adds, and a last item also writes
// sum2<<16|sum1 into the result register, which drives rsp_valid.
// While a result waits in the result register under stall, a further last item waits
// in the input register and the input stalls; items that are not last keep flowing.
// depends on f32ic_pkg, f32ic_in_reg, f32ic_sum_unit, f32ic_out_reg
module fletcher32_image_checksum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [f32ic_pkg::SUM_WIDTH-1:0]   req_data_word,
   input  logic                              req_lone_byte,
   input  logic                              req_last_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [f32ic_pkg::CHECK_WIDTH-1:0] rsp_check_value
);
   import f32ic_pkg::*;

   item_type               req_item;
   item_type               item;
   logic                   item_valid;
   logic                   slot_free;
   logic                   advance;
   logic                   load;
   logic [CHECK_WIDTH-1:0] check_value;

   assign req_item = '{data_word: req_data_word,
                       lone_byte: req_lone_byte,
                       last_item: req_last_item};

   // held item moves into the sums unless it needs a busy result slot
   assign advance = item_valid && (!item.last_item || slot_free);
   assign load    = advance && item.last_item;

   f32ic_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .advance    (advance),
      .req_stall  (req_stall),
      .item_valid (item_valid),
      .item       (item)
   );

   f32ic_sum_unit u_sum_unit (
      .clock       (clock),
      .reset       (reset),
      .item        (item),
      .advance     (advance),
      .check_value (check_value)
   );

   f32ic_out_reg u_out_reg (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .load_value      (check_value),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .slot_free       (slot_free),
      .rsp_check_value (rsp_check_value)
   );

endmodule

/* rtl/f32ic_checker.sv */
// port-level checks on the checksum block, bound to the top level
// depends on f32ic_pkg and fletcher32_image_checksum_macros.svh
`include "fletcher32_image_checksum_macros.svh"

module f32ic_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [f32ic_pkg::SUM_WIDTH-1:0]   req_data_word,
   input logic                              req_lone_byte,
   input logic                              req_last_item,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [f32ic_pkg::CHECK_WIDTH-1:0] rsp_check_value
);
   import f32ic_pkg::*;

   logic                 req_transfer;
   logic                 last_transfer;
   logic                 req_held;
   logic                 rsp_held;
   logic [SUM_WIDTH+1:0] req_payload;

   assign req_transfer  = req_valid && !req_stall;
   assign last_transfer = req_transfer && req_last_item;
   assign req_held      = req_valid && req_stall;
   assign rsp_held      = rsp_valid && rsp_stall;
   assign req_payload   = {req_data_word, req_lone_byte, req_last_item};

   // a new result only follows a last item that has passed the input register into the result register
   `F32IC_ASSERT_IMPLY(a_result_cause, clock, reset, $rose(rsp_valid), $past(last_transfer, 2))

   // input only stalls behind a result that is itself stalled
   `F32IC_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // a stalled result stays put
   `F32IC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_check_value))

   // a stalled input item stays put
   `F32IC_ASSERT_NEXT(a_req_hold, clock, reset, req_held, req_valid && $stable(req_payload))

endmodule

bind fletcher32_image_checksum f32ic_checker u_f32ic_checker (.*);

/* bench/tb_fletcher32_image_checksum.sv */
// self-checking bench for fletcher32_image_checksum: directed, random, hold-off and burst tests
// depends on f32ic_pkg and the rtl of fletcher32_image_checksum
module tb_fletcher32_image_checksum;
   timeunit 1ns;
   timeprecision 1ps;

   import f32ic_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 5;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLDOFF_CYCLES = 250;
   localparam int RANDOM_ITEMS   = 1450;
   localparam int BURST_ITEMS    = 200;
   localparam int MAX_PRINTS     = 100;

   typedef logic [SUM_WIDTH-1:0]   sum_type;
   typedef logic [CHECK_WIDTH-1:0] check_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   sum_type   req_data_word = '0;
   logic      req_lone_byte = 1'b0;
   logic      req_last_item = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   check_type rsp_check_value;

   // running sums of the image in flight and checksums still owed by the block
   sum_type   run_sum = SUM_RESET;
   sum_type   run_sum_of_sums = SUM_RESET;
   check_type pending_checksums[$];

   int error_count = 0;
   int cycle_count = 0;
   bit sender_gaps = 1'b0;
   bit receiver_stalls = 1'b0;
   bit holdoff_request = 1'b0;

   fletcher32_image_checksum dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_lone_byte   (req_lone_byte),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_check_value (rsp_check_value)
   );

   // clock generation
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // mostly no idle, often a short one, now and then a long one
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return 0;
      else if (pick < 92) return $urandom_range(3, 1);
      else return $urandom_range(60, 12);
   endfunction

   // ones-complement style add: a carry out of 16 bits wraps back in at bit 0
   function automatic sum_type wrap_add(sum_type a, sum_type b);
      int total;
      total = int'(a) + int'(b);
      if (total > int'(SUM_RESET)) total = total - int'(SUM_RESET);
      return sum_type'(total);
   endfunction

   // pixel word biased toward the all-ones and all-zeros extremes
   function automatic sum_type pick_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return '1;
      else if (pick < 14) return '0;
      else return sum_type'($urandom);
   endfunction

   // fold one accepted item into the predicted sums, queue a checksum on a last item
   task automatic absorb_item(sum_type word, bit lone, bit last);
      sum_type addend;
      addend = lone ? sum_type'(word[BYTE_WIDTH-1:0]) : word;
      run_sum = wrap_add(run_sum, addend);
      run_sum_of_sums = wrap_add(run_sum_of_sums, run_sum);
      if (last) begin
         pending_checksums.push_back({run_sum_of_sums, run_sum});
         run_sum = SUM_RESET;
         run_sum_of_sums = SUM_RESET;
      end
   endtask

   // offer one item and wait for its transfer; entered and left at a rising edge
   task automatic send_item(sum_type word, bit lone, bit last);
      int gap;
      gap = sender_gaps ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_word <= word;
      req_lone_byte <= lone;
      req_last_item <= last;
      do @(posedge clock); while (req_stall);
      absorb_item(word, lone, last);
   endtask

   // one image of random words; noise puts stray lone bytes mid-stream
   task automatic send_image(int length, bit lone_tail, bit noise);
      bit last;
      bit lone;
      for (int i = 0; i < length; i++) begin
         last = (i == length - 1);
         lone = last ? lone_tail : (noise && $urandom_range(99) < 3);
         send_item(pick_word(), lone, last);
      end
   endtask

   // stop offering and wait until every owed checksum has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_checksums.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, check_type got, check_type want);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("mismatch at cycle %0d: %s got %08h expected %08h",
                  cycle_count, what, got, want);
   endtask

   // extremes, lone byte cases and the upper half ignored under a lone byte
   task automatic test_directed();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      send_item(16'h0000, 1'b0, 1'b1);
      send_item(16'hffff, 1'b0, 1'b1);
      send_item(16'hab12, 1'b1, 1'b1);
      send_item(16'hff00, 1'b1, 1'b1);
      send_item(16'h00ff, 1'b1, 1'b1);
      // lone byte in the middle of an image keeps the sums going
      send_item(16'h1234, 1'b0, 1'b0);
      send_item(16'h5678, 1'b1, 1'b0);
      send_item(16'h9abc, 1'b0, 1'b1);
      for (int i = 0; i < 5; i++) send_item(16'hffff, 1'b0, i == 4);
      for (int i = 0; i < 5; i++) send_item(16'h0000, 1'b0, i == 4);
      send_item(16'h8000, 1'b0, 1'b0);
      send_item(16'h7fff, 1'b0, 1'b0);
      send_item(16'h00ff, 1'b1, 1'b1);
      send_item(16'h0001, 1'b0, 1'b0);
      send_item(16'hfffe, 1'b0, 1'b1);
      wait_for_results();
   endtask

   // random images, mostly short, a few long enough to wrap the sums many times
   task automatic test_random_images();
      int sent;
      int length;
      sent = 0;
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 92) length = $urandom_range(24, 1);
         else length = $urandom_range(400, 60);
         send_image(length, $urandom_range(99) < 35, 1'b1);
         sent += length;
      end
      wait_for_results();
   endtask

   // receiver holds off while short images keep coming, so the input backs up
   task automatic test_receiver_holdoff();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      holdoff_request = 1'b1;
      for (int i = 0; i < 60; i++) send_image($urandom_range(3, 1), 1'($urandom_range(1)), 1'b0);
      wait_for_results();
   endtask

   // back-to-back transfers with no idling on either side
   task automatic test_full_rate();
      int sent;
      int length;
      sent = 0;
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      while (sent < BURST_ITEMS) begin
         length = $urandom_range(8, 1);
         send_image(length, 1'($urandom_range(1)), 1'b1);
         sent += length;
      end
      wait_for_results();
   endtask

   // receiver stall: own hold-off counter, else random stalls when enabled
   int stall_left = 0;
   int run_left = 0;
   int holdoff_left = 0;

   always @(posedge clock) begin
      if (holdoff_request) begin
         holdoff_request = 1'b0;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (!receiver_stalls) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (run_left > 0) begin
            run_left--;
         end else begin
            stall_left = idle_length();
            run_left = $urandom_range(12);
         end
      end
   end

   // compare each result transfer with the oldest owed checksum
   always @(posedge clock) begin : result_check
      check_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_checksums.size() == 0) begin
            report_mismatch("unexpected check_value", rsp_check_value, '0);
         end else begin
            want = pending_checksums.pop_front();
            if (rsp_check_value !== want) report_mismatch("check_value", rsp_check_value, want);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_images();
      test_receiver_holdoff();
      test_full_rate();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
